@@ design/ipm_pkg.sv @@
// ipm_pkg: widths, register codes, reset values and constant tables of the
// peak meter ballistics unit. Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package ipm_pkg;

	localparam int LOG_TABLE_BITS  = 6;
	localparam int PIXEL_FRAC_BITS = 8;

	localparam int AMP_W      = 16;
	localparam int PIX_W      = 21;
	localparam int HEIGHT_W   = 12;
	localparam int FACTOR_W   = 32;
	localparam int TICKS_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_METER_HEIGHT      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_DECAY_START = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_DECAY_START  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_HOLD_TICKS   = 2'd3;

	localparam logic [HEIGHT_W-1:0] METER_HEIGHT_RST      = 12'd256;
	localparam logic [FACTOR_W-1:0] LEVEL_DECAY_START_RST = 32'd4294838447;
	localparam logic [FACTOR_W-1:0] PEAK_DECAY_START_RST  = 32'd4294966008;
	localparam logic [TICKS_W-1:0]  PEAK_HOLD_TICKS_RST   = 8'd100;

	typedef logic [AMP_W-1:0]      amp_t;
	typedef logic [PIX_W-1:0]      pix_t;
	typedef logic [FACTOR_W-1:0]   factor_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	// shared multiplier
	localparam int MUL_W = 32;

	// log2 and dB, Q.16
	localparam int LOG_MAG_W = 20;
	localparam int DB_W      = 25;
	typedef logic signed [DB_W-1:0] db_t;
	localparam logic [MUL_W-1:0] DB_PER_LOG2_Q16 = 32'd394566;
	localparam db_t DB_MIN   = DB_W'(-70 * 65536);
	localparam db_t DB_MAX   = DB_W'(4 * 65536);
	localparam db_t DB_SEG_1 = DB_W'(-60 * 65536);
	localparam db_t DB_SEG_2 = DB_W'(-50 * 65536);
	localparam db_t DB_SEG_3 = DB_W'(-40 * 65536);
	localparam db_t DB_SEG_4 = DB_W'(-30 * 65536);
	localparam db_t DB_SEG_5 = DB_W'(-20 * 65536);

	// scale times 400, Q.16, and its conversion to pixels
	localparam int SEG_D_W   = 21;
	localparam int SLOPE_W   = 4;
	localparam int OFFSET_W  = 8;
	localparam int LV_W      = 25;
	localparam int PIX_SHIFT = 20 - PIXEL_FRAC_BITS;
	localparam int HGT_PROD_W = LV_W + HEIGHT_W;
	localparam int Q1_W      = HGT_PROD_W - PIX_SHIFT;
	localparam logic [MUL_W-1:0] RECIP_25 = 32'd171798691;
	localparam logic [4:0]       DIV_25   = 5'd25;

	localparam pix_t PIX_MAX  = {PIX_W{1'b1}};
	localparam pix_t PIX_MASK = ~PIX_W'((1 << PIXEL_FRAC_BITS) - 1);

	localparam int TBL_SIZE = 1 << LOG_TABLE_BITS;

	// log2(1 + idx / TBL_SIZE) in Q0.16 by repeated squaring
	function automatic logic [15:0] log2_frac_calc(input int unsigned idx);
		logic [63:0] x;
		logic [15:0] r;
		x = 64'(TBL_SIZE + idx) << (30 - LOG_TABLE_BITS);
		r = '0;
		for (int k = 0; k < 16; k++) begin
			x = (x * x) >> 30;
			r = r << 1;
			if (x >= (64'd2 << 30)) begin
				x = x >> 1;
				r = r | 16'd1;
			end
		end
		return r;
	endfunction

	function automatic logic [TBL_SIZE*16-1:0] log2_frac_build();
		logic [TBL_SIZE*16-1:0] t;
		t = '0;
		for (int i = 0; i < TBL_SIZE; i++)
			t[i*16 +: 16] = log2_frac_calc(i);
		return t;
	endfunction

	localparam logic [TBL_SIZE*16-1:0] LOG2_FRAC_ROM = log2_frac_build();

endpackage

@@ design/ipm_if.sv @@
// ipm_if: valid/ready channel interfaces of the peak meter ballistics unit
// (sample in, meter out, register write). Depends on ipm_pkg.
`timescale 1ns / 1ps

interface ipm_sample_if import ipm_pkg::*; ();
	logic valid;
	logic ready;
	amp_t peak_amplitude;

	modport source (output valid, output peak_amplitude, input ready);
	modport sink   (input valid, input peak_amplitude, output ready);
endinterface

interface ipm_meter_if import ipm_pkg::*; ();
	logic valid;
	logic ready;
	pix_t shown_level;
	pix_t peak_level;

	modport source (output valid, output shown_level, output peak_level, input ready);
	modport sink   (input valid, input shown_level, input peak_level, output ready);
endinterface

interface ipm_cfg_if import ipm_pkg::*; ();
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/iec_peak_meter_ballistics_unit.sv @@
// iec_peak_meter_ballistics_unit: amplitude to dB, IEC meter scale, level and
// peak ballistics on one shared 32x32 multiplier. Depends on ipm_pkg, ipm_if.
//
// channel  modport  word                          handshake
// sample   sink     peak_amplitude                valid/ready
// meter    source   shown_level, peak_level       valid/ready
// cfg      sink     index, data                   valid/ready (ready always high)
//
// a sequencer walks each accepted word through log, scale, height, reciprocal and
// decay steps on one multiplier, one product a cycle; a falling level adds a check
// step and, if it stays on top, a decay step; a peak past its hold adds decay steps.
// the result sits in an output register, so the next word is taken while it waits.
// a stalled result holds the sequencer only at its final step.
// arst_n clears control, registers to their defaults and the ballistic state.
`timescale 1ns / 1ps

module iec_peak_meter_ballistics_unit import ipm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	ipm_sample_if.sink    sample,
	ipm_meter_if.source   meter,
	ipm_cfg_if.sink       cfg
);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_LOG     = 4'd1;
	localparam logic [3:0] ST_SEG     = 4'd2;
	localparam logic [3:0] ST_SLOPE   = 4'd3;
	localparam logic [3:0] ST_OFFS    = 4'd4;
	localparam logic [3:0] ST_HGT     = 4'd5;
	localparam logic [3:0] ST_RECIP   = 4'd6;
	localparam logic [3:0] ST_FIX     = 4'd7;
	localparam logic [3:0] ST_LVL     = 4'd8;
	localparam logic [3:0] ST_LVL_CHK = 4'd9;
	localparam logic [3:0] ST_LVL_DEC = 4'd10;
	localparam logic [3:0] ST_PEAK    = 4'd11;
	localparam logic [3:0] ST_PK_DEC1 = 4'd12;
	localparam logic [3:0] ST_PK_DEC2 = 4'd13;
	localparam logic [3:0] ST_DONE    = 4'd14;

	logic [3:0] state_q;

	// configuration
	logic [HEIGHT_W-1:0] meter_height_q;
	factor_t             level_decay_start_q;
	factor_t             peak_decay_start_q;
	logic [TICKS_W-1:0]  peak_hold_ticks_q;

	// ballistic state
	pix_t               level_hold_q;
	factor_t            level_decay_q;
	pix_t               peak_value_q;
	logic [TICKS_W-1:0] peak_hold_count_q;
	factor_t            peak_decay_q;

	// datapath
	logic [LOG_MAG_W-1:0] log_mag_q;
	logic                 log_neg_q;
	logic                 amp_zero_q;
	logic [SEG_D_W-1:0]   seg_d_q;
	logic [SLOPE_W-1:0]   seg_s_q;
	logic [OFFSET_W-1:0]  seg_off_q;
	logic [LV_W-1:0]      lv_q;
	logic [Q1_W-1:0]      q1_q;
	pix_t                 y_q;
	logic [2*MUL_W-1:0]   prod_q;

	logic out_valid_q;
	pix_t shown_q;
	pix_t peak_out_q;

	// leading one, normalize, fraction lookup
	logic [3:0]                lead;
	amp_t                      norm;
	logic [LOG_TABLE_BITS-1:0] idx;
	logic [15:0]               frac;
	logic signed [5:0]         l_int;
	logic signed [21:0]        l_val;
	logic [21:0]               l_mag;

	always_comb begin
		lead = '0;
		for (int i = 0; i < AMP_W; i++)
			if (sample.peak_amplitude[i])
				lead = 4'(i);
		norm  = sample.peak_amplitude << (4'd15 - lead);
		idx   = norm[14 -: LOG_TABLE_BITS];
		frac  = LOG2_FRAC_ROM[{idx, 4'b0000} +: 16];
		l_int = $signed({2'b00, lead}) - 6'sd14;
		l_val = $signed({l_int, 16'h0000}) + $signed({6'b000000, frac});
		l_mag = l_val[21] ? (22'd0 - 22'(l_val)) : 22'(l_val);
	end

	// dB, clamp and segment select
	logic [22:0] db_mag;
	db_t         db_raw;
	db_t         db;
	db_t         seg_base;
	db_t         seg_diff;
	logic [SLOPE_W-1:0]  seg_s;
	logic [OFFSET_W-1:0] seg_off;

	always_comb begin
		db_mag = prod_q[16 +: 23];
		db_raw = log_neg_q ? -$signed({2'b00, db_mag}) : $signed({2'b00, db_mag});
		if (amp_zero_q || db_raw < DB_MIN)
			db = DB_MIN;
		else if (db_raw > DB_MAX)
			db = DB_MAX;
		else
			db = db_raw;
		if (db < DB_SEG_1) begin
			seg_base = DB_MIN;   seg_s = 4'd1;  seg_off = 8'd0;
		end else if (db < DB_SEG_2) begin
			seg_base = DB_SEG_1; seg_s = 4'd2;  seg_off = 8'd10;
		end else if (db < DB_SEG_3) begin
			seg_base = DB_SEG_2; seg_s = 4'd3;  seg_off = 8'd30;
		end else if (db < DB_SEG_4) begin
			seg_base = DB_SEG_3; seg_s = 4'd6;  seg_off = 8'd60;
		end else if (db < DB_SEG_5) begin
			seg_base = DB_SEG_4; seg_s = 4'd8;  seg_off = 8'd120;
		end else begin
			seg_base = DB_SEG_5; seg_s = 4'd10; seg_off = 8'd200;
		end
		seg_diff = db - seg_base;
	end

	// divide by 25 fixup: the reciprocal estimate is low by at most one
	logic [Q1_W-1:0] est;
	logic [Q1_W-1:0] est_x25;
	logic [Q1_W-1:0] rem;
	logic [Q1_W-1:0] y_full;
	logic [63:0]     y_wide;
	pix_t            y_sat;

	always_comb begin
		est     = prod_q[MUL_W +: Q1_W];
		est_x25 = (est << 4) + (est << 3) + est;
		rem     = q1_q - est_x25;
		y_full  = (rem >= Q1_W'(DIV_25)) ? est + Q1_W'(1) : est;
		y_wide  = 64'(y_full);
		y_sat   = (y_wide > 64'(PIX_MAX)) ? PIX_MAX : y_wide[PIX_W-1:0];
	end

	// shared multiplier
	logic [MUL_W-1:0]   mul_a;
	logic [MUL_W-1:0]   mul_b;
	logic [2*MUL_W-1:0] mul_p;

	always_comb begin
		case (state_q)
			ST_LOG: begin
				mul_a = MUL_W'(log_mag_q);
				mul_b = DB_PER_LOG2_Q16;
			end
			ST_SLOPE: begin
				mul_a = MUL_W'(seg_d_q);
				mul_b = MUL_W'(seg_s_q);
			end
			ST_HGT: begin
				mul_a = MUL_W'(lv_q);
				mul_b = MUL_W'(meter_height_q);
			end
			ST_RECIP: begin
				mul_a = MUL_W'(prod_q[PIX_SHIFT +: Q1_W]);
				mul_b = RECIP_25;
			end
			ST_LVL: begin
				mul_a = MUL_W'(level_hold_q);
				mul_b = level_decay_q;
			end
			ST_LVL_CHK: begin
				mul_a = level_decay_q;
				mul_b = level_decay_q;
			end
			ST_PEAK: begin
				mul_a = MUL_W'(peak_value_q);
				mul_b = peak_decay_q;
			end
			ST_PK_DEC1: begin
				mul_a = peak_decay_q;
				mul_b = peak_decay_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
	end

	pix_t         lh_decayed;
	logic [8:0]   hold_next;

	assign lh_decayed = prod_q[MUL_W +: PIX_W] & PIX_MASK;
	assign hold_next  = {1'b0, peak_hold_count_q} + 9'd1;

	assign sample.ready = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign meter.valid       = out_valid_q;
	assign meter.shown_level = shown_q;
	assign meter.peak_level  = peak_out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meter_height_q      <= METER_HEIGHT_RST;
			level_decay_start_q <= LEVEL_DECAY_START_RST;
			peak_decay_start_q  <= PEAK_DECAY_START_RST;
			peak_hold_ticks_q   <= PEAK_HOLD_TICKS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_METER_HEIGHT:      meter_height_q      <= cfg.data[HEIGHT_W-1:0];
				REG_LEVEL_DECAY_START: level_decay_start_q <= cfg.data[FACTOR_W-1:0];
				REG_PEAK_DECAY_START:  peak_decay_start_q  <= cfg.data[FACTOR_W-1:0];
				REG_PEAK_HOLD_TICKS:   peak_hold_ticks_q   <= cfg.data[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				log_mag_q  <= l_mag[LOG_MAG_W-1:0];
				log_neg_q  <= l_val[21];
				amp_zero_q <= (sample.peak_amplitude == '0);
			end
			ST_SEG: begin
				seg_d_q   <= seg_diff[SEG_D_W-1:0];
				seg_s_q   <= seg_s;
				seg_off_q <= seg_off;
			end
			ST_OFFS: lv_q <= prod_q[LV_W-1:0] + {seg_off_q, 16'h0000};
			ST_RECIP: q1_q <= prod_q[PIX_SHIFT +: Q1_W];
			ST_FIX: y_q <= y_sat;
			ST_LVL_CHK: begin
				if (!(lh_decayed < y_q))
					y_q <= lh_decayed;
			end
			default: ;
		endcase
	end

	// sequencer and ballistic state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			level_hold_q      <= '0;
			level_decay_q     <= LEVEL_DECAY_START_RST;
			peak_value_q      <= '0;
			peak_hold_count_q <= '0;
			peak_decay_q      <= PEAK_DECAY_START_RST;
			out_valid_q       <= 1'b0;
		end else begin
			if (meter.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (sample.valid)
						state_q <= ST_LOG;
				end
				ST_LOG:   state_q <= ST_SEG;
				ST_SEG:   state_q <= ST_SLOPE;
				ST_SLOPE: state_q <= ST_OFFS;
				ST_OFFS:  state_q <= ST_HGT;
				ST_HGT:   state_q <= ST_RECIP;
				ST_RECIP: state_q <= ST_FIX;
				ST_FIX:   state_q <= ST_LVL;
				ST_LVL: begin
					if (level_hold_q < y_q) begin
						level_hold_q  <= y_q;
						level_decay_q <= level_decay_start_q;
						state_q       <= ST_PEAK;
					end else begin
						state_q <= ST_LVL_CHK;
					end
				end
				ST_LVL_CHK: begin
					if (lh_decayed < y_q) begin
						level_hold_q <= y_q;
						state_q      <= ST_PEAK;
					end else begin
						level_hold_q <= lh_decayed;
						state_q      <= ST_LVL_DEC;
					end
				end
				ST_LVL_DEC: begin
					level_decay_q <= prod_q[MUL_W +: FACTOR_W];
					state_q       <= ST_PEAK;
				end
				ST_PEAK: begin
					if (peak_value_q < y_q) begin
						peak_value_q      <= y_q;
						peak_hold_count_q <= '0;
						peak_decay_q      <= peak_decay_start_q;
						state_q           <= ST_DONE;
					end else begin
						peak_hold_count_q <= hold_next[8] ? '1 : hold_next[TICKS_W-1:0];
						if (hold_next > {1'b0, peak_hold_ticks_q})
							state_q <= ST_PK_DEC1;
						else
							state_q <= ST_DONE;
					end
				end
				ST_PK_DEC1: begin
					peak_value_q <= prod_q[MUL_W +: PIX_W];
					state_q      <= ST_PK_DEC2;
				end
				ST_PK_DEC2: begin
					peak_decay_q <= prod_q[MUL_W +: FACTOR_W];
					state_q      <= ST_DONE;
				end
				ST_DONE: begin
					// wait for the output register to free up
					if (!out_valid_q || meter.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || meter.ready)) begin
			shown_q    <= y_q;
			peak_out_q <= peak_value_q;
		end
	end

	a_accept_starts_log: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> state_q == ST_LOG)
		else $error("accepted word did not start the log step");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the final step");

	a_level_decay_owner: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(level_decay_q) |-> $past(state_q == ST_LVL || state_q == ST_LVL_DEC))
		else $error("level decay changed outside the level steps");

	a_peak_decay_owner: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(peak_decay_q) |-> $past(state_q == ST_PEAK || state_q == ST_PK_DEC2))
		else $error("peak decay changed outside the peak steps");

endmodule

@@ tb/meter_checker.sv @@
// meter_checker: predicts the shown level and held peak of every accepted sample
// word and compares them with the meter words, oldest first. Depends on ipm_pkg, ipm_if.
`timescale 1ns / 1ps

module meter_checker import ipm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	ipm_sample_if sample,
	ipm_meter_if  meter,
	ipm_cfg_if    cfg,
	output int    pending,
	output int    fail_count
);

	localparam logic [11:0] HEIGHT_DEFAULT      = 12'd256;
	localparam factor_t     LEVEL_DECAY_DEFAULT = 32'd4294838447;
	localparam factor_t     PEAK_DECAY_DEFAULT  = 32'd4294966008;
	localparam logic [7:0]  HOLD_DEFAULT        = 8'd100;

	localparam longint DB_FLOOR    = -70 * 65536;
	localparam longint DB_CEIL     = 4 * 65536;
	localparam longint DB_PER_LOG2 = 394566;

	typedef struct packed {
		pix_t shown;
		pix_t peak;
	} meter_word_t;

	meter_word_t meter_words_due [$];
	int          errors = 0;

	// register copies
	logic [11:0] height;
	factor_t     level_decay_init;
	factor_t     peak_decay_init;
	logic [7:0]  hold_ticks;

	// ballistic state
	pix_t        level_hold;
	factor_t     level_decay;
	pix_t        peak_val;
	logic [7:0]  hold_count;
	factor_t     peak_decay;

	assign fail_count = errors;

	// log2(1 + m / 2^LOG_TABLE_BITS) in Q0.16, one bit per squaring
	function automatic logic [15:0] log2_mantissa(int unsigned m);
		logic [63:0] acc;
		logic [15:0] bits;
		int          k;
		acc  = 64'((1 << LOG_TABLE_BITS) + m) << (30 - LOG_TABLE_BITS);
		bits = '0;
		for (k = 0; k < 16; k++) begin
			acc  = (acc * acc) >> 30;
			bits = {bits[14:0], 1'b0};
			if (acc >= 64'h8000_0000) begin
				acc     = acc >> 1;
				bits[0] = 1'b1;
			end
		end
		return bits;
	endfunction

	function automatic longint amplitude_db(amp_t a);
		int          lead;
		int unsigned m;
		longint      lg;
		longint      db;
		if (a == '0)
			return DB_FLOOR;
		lead = 15;
		while (lead > 0 && !a[lead])
			lead--;
		if (lead >= LOG_TABLE_BITS)
			m = 32'(a) >> (lead - LOG_TABLE_BITS);
		else
			m = 32'(a) << (LOG_TABLE_BITS - lead);
		m  = m & ((1 << LOG_TABLE_BITS) - 1);
		lg = longint'(lead - 14) * 65536 + longint'(log2_mantissa(m));
		db = (lg * DB_PER_LOG2) / 65536;
		if (db < DB_FLOOR) db = DB_FLOOR;
		if (db > DB_CEIL)  db = DB_CEIL;
		return db;
	endfunction

	// iec meter scale times 400, Q.16
	function automatic longint iec_scale_x400(longint db);
		longint base;
		longint slope;
		longint offs;
		if (db < -60 * 65536) begin
			base = -70; slope = 1; offs = 0;
		end else if (db < -50 * 65536) begin
			base = -60; slope = 2; offs = 10;
		end else if (db < -40 * 65536) begin
			base = -50; slope = 3; offs = 30;
		end else if (db < -30 * 65536) begin
			base = -40; slope = 6; offs = 60;
		end else if (db < -20 * 65536) begin
			base = -30; slope = 8; offs = 120;
		end else begin
			base = -20; slope = 10; offs = 200;
		end
		return slope * (db - base * 65536) + offs * 65536;
	endfunction

	function automatic factor_t scale_q32(factor_t x, factor_t f);
		logic [63:0] prod;
		prod = 64'(x) * 64'(f);
		return prod[63:32];
	endfunction

	function automatic meter_word_t ballistics_step(amp_t a);
		longint unsigned lv;
		longint unsigned px;
		pix_t            y;
		int              nxt;
		meter_word_t     w;
		lv = longint'(iec_scale_x400(amplitude_db(a)));
		px = ((lv * 64'(height)) << PIXEL_FRAC_BITS) / (64'd400 * 64'd65536);
		y  = (px > 64'(PIX_MAX)) ? PIX_MAX : pix_t'(px);

		if (level_hold < y) begin
			level_hold  = y;
			level_decay = level_decay_init;
		end else begin
			// falling level drops to whole pixels
			level_hold = pix_t'(scale_q32(32'(level_hold), level_decay)
				& ~32'((1 << PIXEL_FRAC_BITS) - 1));
			if (level_hold < y) begin
				level_hold = y;
			end else begin
				level_decay = scale_q32(level_decay, level_decay);
				y = level_hold;
			end
		end

		if (peak_val < y) begin
			peak_val   = y;
			hold_count = '0;
			peak_decay = peak_decay_init;
		end else begin
			// compare uses the unsaturated count so the peak always falls
			nxt        = int'(hold_count) + 1;
			hold_count = (nxt > 255) ? 8'd255 : 8'(nxt);
			if (nxt > int'(hold_ticks)) begin
				peak_val   = pix_t'(scale_q32(32'(peak_val), peak_decay));
				peak_decay = scale_q32(peak_decay, peak_decay);
			end
		end

		w.shown = y;
		w.peak  = peak_val;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		meter_word_t want;
		if (!arst_n) begin
			height           = HEIGHT_DEFAULT;
			level_decay_init = LEVEL_DECAY_DEFAULT;
			peak_decay_init  = PEAK_DECAY_DEFAULT;
			hold_ticks       = HOLD_DEFAULT;
			level_hold       = '0;
			level_decay      = LEVEL_DECAY_DEFAULT;
			peak_val         = '0;
			hold_count       = '0;
			peak_decay       = PEAK_DECAY_DEFAULT;
			meter_words_due.delete();
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_METER_HEIGHT:      height           = cfg.data[11:0];
					REG_LEVEL_DECAY_START: level_decay_init = cfg.data;
					REG_PEAK_DECAY_START:  peak_decay_init  = cfg.data;
					REG_PEAK_HOLD_TICKS:   hold_ticks       = cfg.data[7:0];
					default: ;
				endcase
			end
			if (meter.valid && meter.ready) begin
				if (meter_words_due.size() == 0) begin
					$error("meter word with none due: shown_level %0d peak_level %0d",
						meter.shown_level, meter.peak_level);
					errors++;
				end else begin
					want = meter_words_due.pop_front();
					if (meter.shown_level !== want.shown) begin
						$error("shown_level expected %0d got %0d", want.shown, meter.shown_level);
						errors++;
					end
					if (meter.peak_level !== want.peak) begin
						$error("peak_level expected %0d got %0d", want.peak, meter.peak_level);
						errors++;
					end
				end
			end
			if (sample.valid && sample.ready)
				meter_words_due.push_back(ballistics_step(sample.peak_amplitude));
			pending <= meter_words_due.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
// testbench: drives sample words and register writes into the peak meter unit,
// stalls the meter side at random and gives the verdict. Depends on ipm_pkg,
// ipm_if, the unit itself and meter_checker.
`timescale 1ns / 1ps

module testbench import ipm_pkg::*;;

	localparam int PHASES          = 9;
	localparam int WORDS_PER_PHASE = 208;
	localparam int STALL_LIMIT     = 2000;
	localparam int DRAIN_CYCLES    = 40;

	logic clk;
	logic arst_n;
	int   pending;
	int   fail_count;
	int   src_idle_pct;
	int   snk_idle_pct;
	int   idle_cycles;

	ipm_sample_if sample_ch ();
	ipm_meter_if  meter_ch ();
	ipm_cfg_if    cfg_ch ();

	iec_peak_meter_ballistics_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.meter  (meter_ch),
		.cfg    (cfg_ch)
	);

	meter_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample_ch),
		.meter      (meter_ch),
		.cfg        (cfg_ch),
		.pending    (pending),
		.fail_count (fail_count)
	);

	// zero, segment edges of the iec scale, full scale, the +4 dB clamp, all ones
	amp_t edge_amps [18] = '{16'd0, 16'd1, 16'd2, 16'd5, 16'd6, 16'd16, 16'd17, 16'd52,
		16'd164, 16'd518, 16'd1638, 16'd16384, 16'd25968, 16'd25969, 16'd32768,
		16'd65535, 16'h5555, 16'hAAAA};

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		meter_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

	always @(posedge clk) begin
		if (!arst_n || (sample_ch.valid && sample_ch.ready) || (meter_ch.valid && meter_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("iec_peak_meter_ballistics_unit verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_amplitude(input amp_t a);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid          <= 1'b1;
		sample_ch.peak_amplitude <= a;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	task automatic write_register(input cfg_idx_t idx, input cfg_data_t value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic program_meter(input logic [11:0] h, input factor_t ld, input factor_t pd,
			input logic [7:0] ticks);
		// junk in the unused upper bits must be ignored
		write_register(REG_METER_HEIGHT, {20'($urandom), h});
		write_register(REG_LEVEL_DECAY_START, ld);
		write_register(REG_PEAK_DECAY_START, pd);
		write_register(REG_PEAK_HOLD_TICKS, {24'($urandom), ticks});
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic factor_t pick_decay();
		case ($urandom_range(0, 3))
			0:       return 32'hFFFF_FFFF - $urandom_range(0, 1 << 20);
			1:       return $urandom;
			2:       return 32'hFFFF_FFFF;
			default: return 32'hF000_0000 | ($urandom & 32'h0FFF_FFFF);
		endcase
	endfunction

	// log-spread amplitude so every dB segment gets traffic
	function automatic amp_t spread_amp(input int min_shift);
		return amp_t'($urandom_range(0, 65535) >> $urandom_range(min_shift, 15));
	endfunction

	initial begin
		int sent;
		int run;
		int ph;
		arst_n                   = 1'b0;
		sample_ch.valid          = 1'b0;
		sample_ch.peak_amplitude = '0;
		cfg_ch.valid             = 1'b0;
		cfg_ch.index             = REG_METER_HEIGHT;
		cfg_ch.data              = '0;
		src_idle_pct             = 0;
		snk_idle_pct             = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (ph = 0; ph < PHASES; ph++) begin
			// receiver lazy first, then sender lazy, then no gaps
			src_idle_pct <= (ph < 3) ? 9 : (ph < 6) ? 49 : 0;
			snk_idle_pct <= (ph < 3) ? 49 : (ph < 6) ? 9 : 0;
			sent = 0;
			case (ph)
				0: begin
					@(posedge clk);
					foreach (edge_amps[i])
						send_amplitude(edge_amps[i]);
				end
				1: begin
					program_meter(12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
					// long quiet run lets the hold count saturate
					send_amplitude(16'd65535);
					repeat (280) send_amplitude(16'd0);
					sent = 281;
				end
				2: program_meter(12'd1, 32'd0, 32'd0, 8'd0);
				3: program_meter(12'd0, pick_decay(), pick_decay(), 8'($urandom));
				default: program_meter(12'($urandom_range(1, 4095)), pick_decay(), pick_decay(),
					8'($urandom));
			endcase

			while (sent < WORDS_PER_PHASE) begin
				send_amplitude(($urandom_range(0, 4) == 0) ? amp_t'($urandom) : spread_amp(0));
				sent++;
				run = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 12);
				repeat (run) begin
					send_amplitude(($urandom_range(0, 3) == 0) ? 16'd0 : spread_amp(4));
					sent++;
				end
			end
			sample_ch.valid <= 1'b0;
			do @(posedge clk); while (pending != 0);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("iec_peak_meter_ballistics_unit verification clean");
		else
			$display("iec_peak_meter_ballistics_unit verification failed");
		$finish;
	end

endmodule
